/* hdl/signed_frame_parser_macros.svh */
`ifndef SIGNED_FRAME_PARSER_MACROS_SVH
`define SIGNED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SFP_ASSERT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfp assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SFP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfp assertion failed");

`endif

/* hdl/sfp_pkg.sv */
`timescale 1ns / 1ps

package sfp_pkg;

	localparam int CNT_W        = 33;
	localparam int HDR_BYTES    = 4 + 1 + 1 + 2 + 1 + 1 + 20 + 8 + 8 + 8 + 8 + 16 + 4;
	localparam int NONCE_LONG   = 24;
	localparam int NONCE_SHORT  = 12;
	localparam int SIG_BYTES    = 64;
	localparam int KEYID_BYTES  = 4;
	localparam int CHUNK_BYTES  = 28;
	localparam int TRANSFER_ID_BYTES = 16;

	// Header byte positions
	localparam int POS_VERSION  = 4;
	localparam int POS_FLAGS_LO = 6;
	localparam int POS_FLAGS_HI = 7;
	localparam int POS_SUITE    = 8;
	localparam int POS_BODY_B0  = 78;
	localparam int POS_BODY_B1  = 79;
	localparam int POS_BODY_B2  = 80;
	localparam int POS_BODY_B3  = 81;

	localparam logic [7:0] SUITE_LONG  = 8'd1;
	localparam logic [7:0] SUITE_SHORT = 8'd2;

	localparam logic [4:0] SEC_MAGIC       = 5'd0;
	localparam logic [4:0] SEC_KEY_ID      = 5'd13;
	localparam logic [4:0] SEC_TRANSFER_ID = 5'd14;
	localparam logic [4:0] SEC_CHUNK_INDEX = 5'd15;
	localparam logic [4:0] SEC_NONCE       = 5'd18;
	localparam logic [4:0] SEC_PAYLOAD     = 5'd19;
	localparam logic [4:0] SEC_SIGNATURE   = 5'd20;
	localparam logic [4:0] SEC_DISCARD     = 5'd21;

	typedef enum logic [1:0] {
		CFG_MAGIC_WORD   = 2'd0,
		CFG_WIRE_VERSION = 2'd1,
		CFG_KEY_ID_MASK  = 2'd2,
		CFG_CHUNKED_MASK = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_VERSION = 3'd3,
		ST_LENGTH  = 3'd4,
		ST_NO_SIG  = 3'd5,
		ST_SUITE   = 3'd6,
		ST_FRAMING = 3'd7
	} status_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [7:0]  wire_version;
		logic [15:0] key_id_flag_mask;
		logic [15:0] chunked_flag_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [4:0] section;
		logic [5:0] section_offset;
		logic       frame_done;
		logic [2:0] status;
	} res_t;

	// Header field that a byte position falls in
	function automatic logic [4:0] hdr_section(input logic [6:0] p);
		logic [4:0] s;
		if (p >= 7'd78)      s = 5'd12;
		else if (p >= 7'd62) s = 5'd11;
		else if (p >= 7'd54) s = 5'd10;
		else if (p >= 7'd46) s = 5'd9;
		else if (p >= 7'd38) s = 5'd8;
		else if (p >= 7'd30) s = 5'd7;
		else if (p >= 7'd10) s = 5'd6;
		else if (p >= 7'd9)  s = 5'd5;
		else if (p >= 7'd8)  s = 5'd4;
		else if (p >= 7'd6)  s = 5'd3;
		else if (p >= 7'd5)  s = 5'd2;
		else if (p >= 7'd4)  s = 5'd1;
		else                 s = SEC_MAGIC;
		return s;
	endfunction

	function automatic logic [5:0] off_inc(input logic [5:0] o);
		return (o == 6'd63) ? o : o + 6'd1;
	endfunction

endpackage

/* hdl/sfp_if.sv */
`timescale 1ns / 1ps

interface sfp_byte_if ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface sfp_result_if ();
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [4:0] section;
	logic [5:0] section_offset;
	logic       frame_done;
	logic [2:0] status;

	modport source (output valid, output byte_out, output section, output section_offset,
		output frame_done, output status, input ready);
	modport sink (input valid, input byte_out, input section, input section_offset,
		input frame_done, input status, output ready);
endinterface

/* hdl/sfp_cfg.sv */
`timescale 1ns / 1ps

module sfp_cfg import sfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word        <= 32'd0;
			cfg_q.wire_version      <= 8'd1;
			cfg_q.key_id_flag_mask  <= 16'd1;
			cfg_q.chunked_flag_mask <= 16'd2;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_MAGIC_WORD:   cfg_q.magic_word        <= cfg_wdata;
				CFG_WIRE_VERSION: cfg_q.wire_version      <= cfg_wdata[7:0];
				CFG_KEY_ID_MASK:  cfg_q.key_id_flag_mask  <= cfg_wdata[15:0];
				CFG_CHUNKED_MASK: cfg_q.chunked_flag_mask <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/sfp_core.sv */
`timescale 1ns / 1ps
`include "signed_frame_parser_macros.svh"

module sfp_core import sfp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  adv,
	input  item_t item,
	output res_t  res
);

	logic [CNT_W-1:0] byte_count_q;
	logic [CNT_W-1:0] sig_start_q;
	logic [CNT_W-1:0] last_pos_q;
	logic [4:0]       cur_sec_q;
	logic [5:0]       cur_off_q;
	logic [15:0]      flags_q;
	logic [7:0]       suite_q;
	logic [23:0]      body_lo_q;
	status_t          err_q;

	logic [CNT_W-1:0] pos;
	logic [7:0]       b;
	logic [7:0]       p8;
	logic             pos_small;
	logic             in_hdr;
	logic [7:0]       key_len, chunk_len, nonce_size;
	logic [7:0]       key_end, chunk_end, nonce_end, crel, need;
	logic [31:0]      body_full;
	logic             len_bad;
	logic [4:0]       sec;
	logic [5:0]       off;
	status_t          err_d;
	status_t          status_d;

	assign pos       = byte_count_q;
	assign b         = item.data_byte;
	assign p8        = pos[7:0];
	assign pos_small = (pos[CNT_W-1:8] == '0);
	assign in_hdr    = pos_small && (p8 < 8'(HDR_BYTES));

	assign key_len   = |(flags_q & cfg.key_id_flag_mask) ? 8'(KEYID_BYTES) : 8'd0;
	assign chunk_len = |(flags_q & cfg.chunked_flag_mask) ? 8'(CHUNK_BYTES) : 8'd0;

	always_comb begin
		case (suite_q)
			SUITE_LONG:  nonce_size = 8'(NONCE_LONG);
			SUITE_SHORT: nonce_size = 8'(NONCE_SHORT);
			default:     nonce_size = 8'd0;
		endcase
	end

	assign key_end   = 8'(HDR_BYTES) + key_len;
	assign chunk_end = key_end + chunk_len;
	assign nonce_end = chunk_end + nonce_size;
	assign crel      = p8 - key_end;
	assign need      = key_len + chunk_len + nonce_size + 8'(SIG_BYTES);
	assign body_full = {b, body_lo_q};

	// Section of this byte; payload and signature bounds were fixed on the last length byte
	always_comb begin
		if (err_q != ST_OK)
			sec = SEC_DISCARD;
		else if (in_hdr)
			sec = hdr_section(p8[6:0]);
		else if (pos_small && p8 < key_end)
			sec = SEC_KEY_ID;
		else if (pos_small && p8 < chunk_end)
			sec = (crel < 8'(TRANSFER_ID_BYTES)) ? SEC_TRANSFER_ID
				: SEC_CHUNK_INDEX + 5'(crel[4:2]) - 5'd4;
		else if (pos_small && p8 < nonce_end)
			sec = SEC_NONCE;
		else if (pos < sig_start_q)
			sec = SEC_PAYLOAD;
		else if (pos <= last_pos_q)
			sec = SEC_SIGNATURE;
		else
			sec = SEC_DISCARD;
	end

	// Offset restarts whenever the section changes and on the frame's first byte, and stays zero in discard
	always_comb begin
		if (sec == SEC_DISCARD || pos == '0 || sec != cur_sec_q)
			off = 6'd0;
		else
			off = off_inc(cur_off_q);
	end

	always_comb begin
		err_d = err_q;
		if (err_q == ST_OK && in_hdr) begin
			if (p8 < 8'(POS_VERSION)) begin
				if (b != cfg.magic_word[{p8[1:0], 3'b000} +: 8])
					err_d = ST_MAGIC;
			end else if (p8 == 8'(POS_VERSION)) begin
				if (b != cfg.wire_version)
					err_d = ST_VERSION;
			end else if (p8 == 8'(POS_BODY_B3)) begin
				if (body_full < 32'(SIG_BYTES))
					err_d = ST_NO_SIG;
				else if (suite_q > SUITE_SHORT)
					err_d = ST_SUITE;
				else if ({24'd0, need} > body_full)
					err_d = ST_FRAMING;
			end
		end
	end

	assign len_bad = (pos == CNT_W'(POS_BODY_B3)) ? (body_full != '0) : (pos != last_pos_q);

	always_comb begin
		status_d = ST_OK;
		if (item.frame_last) begin
			if (pos_small && p8 < 8'(HDR_BYTES - 1))
				status_d = ST_SHORT;
			else if (err_d == ST_MAGIC || err_d == ST_VERSION)
				status_d = err_d;
			else if (len_bad)
				status_d = ST_LENGTH;
			else
				status_d = err_d;
		end
	end

	assign res.byte_out       = b;
	assign res.section        = sec;
	assign res.section_offset = off;
	assign res.frame_done     = item.frame_last;
	assign res.status         = status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			cur_sec_q    <= SEC_MAGIC;
			cur_off_q    <= '0;
			err_q        <= ST_OK;
			flags_q      <= '0;
			suite_q      <= '0;
		end else if (adv) begin
			if (item.frame_last) begin
				byte_count_q <= '0;
				cur_sec_q    <= SEC_MAGIC;
				cur_off_q    <= '0;
				err_q        <= ST_OK;
			end else begin
				if (byte_count_q != '1)
					byte_count_q <= byte_count_q + 1'b1;
				cur_sec_q <= sec;
				cur_off_q <= off;
				err_q     <= err_d;
			end
			if (err_q == ST_OK && in_hdr) begin
				if (p8 == 8'(POS_FLAGS_LO))
					flags_q[7:0] <= b;
				if (p8 == 8'(POS_FLAGS_HI))
					flags_q[15:8] <= b;
				if (p8 == 8'(POS_SUITE))
					suite_q <= b;
			end
		end
	end

	// Body length bytes and the bounds derived from them
	always_ff @(posedge clk) begin
		if (adv && err_q == ST_OK && in_hdr) begin
			if (p8 == 8'(POS_BODY_B0))
				body_lo_q[7:0] <= b;
			if (p8 == 8'(POS_BODY_B1))
				body_lo_q[15:8] <= b;
			if (p8 == 8'(POS_BODY_B2))
				body_lo_q[23:16] <= b;
			if (p8 == 8'(POS_BODY_B3)) begin
				sig_start_q <= {1'b0, body_full} + CNT_W'(HDR_BYTES - SIG_BYTES);
				last_pos_q  <= {1'b0, body_full} + CNT_W'(HDR_BYTES - 1);
			end
		end
	end

	`SFP_ASSERT_NEXT(a_frame_restart, adv && item.frame_last, byte_count_q == '0 && err_q == ST_OK)
	`SFP_ASSERT_NEXT(a_error_sticky, adv && !item.frame_last && err_q != ST_OK, err_q == $past(err_q))
	`SFP_ASSERT(a_status_only_done, adv && !item.frame_last, res.status == ST_OK)
	`SFP_ASSERT(a_error_discards, adv && err_q != ST_OK, res.section == SEC_DISCARD && res.section_offset == 6'd0)

endmodule

/* hdl/signed_frame_parser.sv */
`timescale 1ns / 1ps

// Signed frame parser: labels every byte of a signed frame with its section.
// byte_ch (sink) takes one frame byte per item, frame_last set on the final
// byte. result_ch (source) returns one item per byte: the byte, its section
// and offset inside the section, frame_done and, on the frame's last byte,
// the frame status. The next frame starts with the byte after frame_last.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 magic
// word, 1 wire version, 2 key id flag mask, 3 chunked flag mask); write only
// while no item is in flight.
// Path: a byte accepted from byte_ch sits in the input register, is labeled
// and lands in the result register, from which result_ch offers it.
// Throughput: one byte per cycle while result_ch does not stall, set by the
// single labeling stage between the two registers.
// When result_ch stalls, the result register holds and the input register
// still takes one more byte; byte_ch.ready drops only when both are full.
// Reset (arst_n low) empties both registers, returns the registers to their
// defaults and puts the parser at the start of a frame.

module signed_frame_parser import sfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sfp_byte_if.sink     byte_ch,
	sfp_result_if.source result_ch,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);

	cfg_t  cfg;
	item_t item_s1;
	logic  vld_s1;
	res_t  res_d;
	res_t  res_q;
	logic  out_vld_q;
	logic  adv;
	logic  in_fire;

	sfp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	sfp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv),
		.item   (item_s1),
		.res    (res_d)
	);

	// Advance the held byte when the result register is free or being drained
	assign adv           = vld_s1 && (!out_vld_q || result_ch.ready);
	assign byte_ch.ready = !vld_s1 || adv;
	assign in_fire       = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1    <= in_fire || (vld_s1 && !adv);
			out_vld_q <= adv || (out_vld_q && !result_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.data_byte  <= byte_ch.data_byte;
			item_s1.frame_last <= byte_ch.frame_last;
		end
		if (adv)
			res_q <= res_d;
	end

	assign result_ch.valid          = out_vld_q;
	assign result_ch.byte_out       = res_q.byte_out;
	assign result_ch.section        = res_q.section;
	assign result_ch.section_offset = res_q.section_offset;
	assign result_ch.frame_done     = res_q.frame_done;
	assign result_ch.status         = res_q.status;

endmodule
